FILE: sv/nps_pkg.sv
`timescale 1ns / 1ps

package nps_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 16;

  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int IDX_W  = 10;
  localparam int DIST_W = 34;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int SUM_W  = SQ_W + 1;
  localparam int PT_W   = 2 * COORD_BITS;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]                   command;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
  } in_t;

  typedef struct packed {
    logic                         found;
    logic signed [COORD_BITS-1:0] nearest_x;
    logic signed [COORD_BITS-1:0] nearest_y;
    logic [IDX_W-1:0]             nearest_index;
    logic [DIST_W-1:0]            distance_squared;
    logic                         store_full;
  } out_t;

  // one stored point entering the distance unit
  typedef struct packed {
    logic                         vld;
    logic                         last;
    logic [ADDR_W-1:0]            idx;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
  } dist_req_t;

  typedef struct packed {
    logic                         vld;
    logic                         last;
    logic [ADDR_W-1:0]            idx;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic [SUM_W-1:0]             dsq;
  } dist_rsp_t;

endpackage

FILE: sv/nps_ram.sv
`timescale 1ns / 1ps

module nps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/nps_dist.sv
`timescale 1ns / 1ps

module nps_dist (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic signed [nps_pkg::COORD_BITS-1:0] qx_i,
  input  logic signed [nps_pkg::COORD_BITS-1:0] qy_i,
  input  nps_pkg::dist_req_t             req_i,
  output nps_pkg::dist_rsp_t             rsp_o
);

  import nps_pkg::*;

  logic signed [COORD_BITS:0] dx, dy, dx_neg, dy_neg;
  logic [COORD_BITS-1:0]      mag_x_d, mag_y_d;

  dist_req_t             s1_q, s2_q, s3_q;
  logic [COORD_BITS-1:0] mag_x_q, mag_y_q;
  logic [SQ_W-1:0]       sq_x_q, sq_y_q;
  logic [SUM_W-1:0]      sum_q;

  // stage 1: absolute differences, one extra bit so the subtraction cannot wrap
  always_comb begin
    dx      = {qx_i[COORD_BITS-1], qx_i} - {req_i.px[COORD_BITS-1], req_i.px};
    dy      = {qy_i[COORD_BITS-1], qy_i} - {req_i.py[COORD_BITS-1], req_i.py};
    dx_neg  = -dx;
    dy_neg  = -dy;
    mag_x_d = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    mag_y_d = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else begin
      s1_q <= req_i;
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_x_q <= mag_x_d;
    mag_y_q <= mag_y_d;
    // stage 2: squares
    sq_x_q  <= SQ_W'(mag_x_q) * SQ_W'(mag_x_q);
    sq_y_q  <= SQ_W'(mag_y_q) * SQ_W'(mag_y_q);
    // stage 3: sum
    sum_q   <= SUM_W'(sq_x_q) + SUM_W'(sq_y_q);
  end

  assign rsp_o.vld  = s3_q.vld;
  assign rsp_o.last = s3_q.last;
  assign rsp_o.idx  = s3_q.idx;
  assign rsp_o.px   = s3_q.px;
  assign rsp_o.py   = s3_q.py;
  assign rsp_o.dsq  = sum_q;

endmodule

FILE: sv/nearest_point_search.sv
`timescale 1ns / 1ps

// Nearest-point search over a store of up to MAX_POINTS signed Q8.8 points.
// Clear and append transactions give no result; an append to a full store is
// dropped and raises store_full until the next clear. A query streams the
// store out of its single RAM read port, one point per cycle, through a
// three-stage squared-distance unit and a running minimum, and the input is
// stalled until its result is written to the output register (an empty
// store skips the scan). The result sits in an output
// register, so the next transaction is taken while it waits to be collected;
// a query that finishes while the previous result is still stalled waits for
// it. Ties go to the earliest stored point.
module nearest_point_search (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  nps_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output nps_pkg::out_t out_data_o
);

  import nps_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic [CNT_W-1:0] rd_cnt_q, rd_cnt_d;

  logic signed [COORD_BITS-1:0] qx_q, qy_q;

  logic                  have_q, have_d;
  logic [ADDR_W-1:0]     best_idx_q;
  logic [SUM_W-1:0]      best_d_q;
  logic signed [COORD_BITS-1:0] best_x_q, best_y_q;
  logic                  best_upd;

  logic                  ram_vld_q, ram_last_q;
  logic [ADDR_W-1:0]     ram_idx_q;
  logic                  scan_last;
  logic                  in_acc;
  logic                  ram_we;
  logic [PT_W-1:0]       ram_rdata;

  dist_req_t dist_req;
  dist_rsp_t dist_rsp;

  logic out_valid_q;
  out_t out_q;
  logic out_free;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign scan_last = (rd_cnt_q + CNT_W'(1)) == count_q;
  assign ram_we    = in_acc && (in_data_i.command == CMD_APPEND) &&
                     (count_q < CNT_W'(MAX_POINTS));
  assign out_free  = !out_valid_q || !out_stall_i;

  nps_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i ({in_data_i.coord_x, in_data_i.coord_y}),
    .raddr_i (rd_cnt_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign dist_req.vld  = ram_vld_q;
  assign dist_req.last = ram_last_q;
  assign dist_req.idx  = ram_idx_q;
  assign dist_req.px   = ram_rdata[PT_W-1:COORD_BITS];
  assign dist_req.py   = ram_rdata[COORD_BITS-1:0];

  nps_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .qx_i   (qx_q),
    .qy_i   (qy_q),
    .req_i  (dist_req),
    .rsp_o  (dist_rsp)
  );

  // strictly smaller only, so the earliest of equal points stays
  assign best_upd = dist_rsp.vld && (!have_q || (dist_rsp.dsq < best_d_q));

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    rd_cnt_d = rd_cnt_q;
    have_d   = have_q || best_upd;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.command)
            CMD_CLEAR: begin
              count_d = '0;
              ovf_d   = 1'b0;
            end
            CMD_APPEND: begin
              if (ram_we) begin
                count_d = count_q + CNT_W'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            CMD_QUERY: begin
              have_d   = 1'b0;
              rd_cnt_d = '0;
              state_d  = (count_q == '0) ? ST_DONE : ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        rd_cnt_d = rd_cnt_q + CNT_W'(1);
        if (scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (dist_rsp.vld && dist_rsp.last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      rd_cnt_q    <= '0;
      have_q      <= 1'b0;
      ram_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      rd_cnt_q  <= rd_cnt_d;
      have_q    <= have_d;
      ram_vld_q <= (state_q == ST_SCAN);
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ram_last_q <= scan_last;
    ram_idx_q  <= rd_cnt_q[ADDR_W-1:0];
    if (in_acc && in_data_i.command == CMD_QUERY) begin
      qx_q <= in_data_i.coord_x;
      qy_q <= in_data_i.coord_y;
    end
    if (best_upd) begin
      best_idx_q <= dist_rsp.idx;
      best_d_q   <= dist_rsp.dsq;
      best_x_q   <= dist_rsp.px;
      best_y_q   <= dist_rsp.py;
    end
    if (state_q == ST_DONE && out_free) begin
      out_q.found            <= have_q;
      out_q.nearest_x        <= have_q ? best_x_q : '0;
      out_q.nearest_y        <= have_q ? best_y_q : '0;
      out_q.nearest_index    <= have_q ? IDX_W'(best_idx_q) : '0;
      out_q.distance_squared <= have_q ? DIST_W'(best_d_q) : '0;
      out_q.store_full       <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: sv/nps_checker.sv
`timescale 1ns / 1ps

module nps_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input nps_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input nps_pkg::out_t out_data_o
);

  import nps_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // not found means all position fields read zero
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |->
      out_data_o.distance_squared == '0 && out_data_o.nearest_index == '0 &&
      out_data_o.nearest_x == '0 && out_data_o.nearest_y == '0)
    else $error("empty result with non-zero fields");

  // an accepted query always raises the input stall
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.command == CMD_QUERY |=> in_stall_o)
    else $error("query did not stall input");

  // a new result only appears at the end of a query
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a query in progress");

endmodule

bind nearest_point_search nps_checker u_nps_checker (.*);

FILE: sim/nearest_point_search_tb.sv
`timescale 1ns / 1ps

module nearest_point_search_tb;
  import nps_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int TAIL_CYCLES = 40;
  localparam int PHASE_ITEMS = 135;

  typedef struct packed {
    in_t  item;
    logic typed;
    out_t res;
  } stim_row_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_stall_i = 1'b0;
  in_t  in_data_i   = '0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;

  // mirror of the point store
  logic signed [COORD_BITS-1:0] pts_x [MAX_POINTS];
  logic signed [COORD_BITS-1:0] pts_y [MAX_POINTS];
  int unsigned n_pts        = 0;
  bit          dropped_flag = 1'b0;

  out_t      nearest_q [$];
  out_t      head_res;
  stim_row_t dir_tab [$];

  int err_cnt    = 0;
  int item_cnt   = 0;
  int res_cnt    = 0;
  int drop_cnt   = 0;
  int max_search = 0;
  int cyc_cnt    = 0;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_left  = 0;
  bit hold_req   = 1'b0;
  bit hold_seen  = 1'b0;

  always #5 clk_i = ~clk_i;

  nearest_point_search i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  function automatic in_t mk_in(logic [1:0] c, int x, int y);
    in_t it;
    it.command = c;
    it.coord_x = x[COORD_BITS-1:0];
    it.coord_y = y[COORD_BITS-1:0];
    return it;
  endfunction

  function automatic out_t res_of(bit f, int x, int y, int idx, logic [DIST_W-1:0] d,
                                  bit full);
    out_t r;
    r.found            = f;
    r.nearest_x        = x[COORD_BITS-1:0];
    r.nearest_y        = y[COORD_BITS-1:0];
    r.nearest_index    = idx[IDX_W-1:0];
    r.distance_squared = d;
    r.store_full       = full;
    return r;
  endfunction

  function automatic stim_row_t mk_row(in_t it, logic typed, out_t r);
    stim_row_t row;
    row.item  = it;
    row.typed = typed;
    row.res   = r;
    return row;
  endfunction

  function automatic int rand_coord();
    if ($urandom_range(1) == 1) return int'($urandom_range(65535)) - 32768;
    return int'($urandom_range(2047)) - 1024;
  endfunction

  // updates the mirrored store and returns 1 when the transaction yields a result
  function automatic bit search_step(in_t it, output out_t r);
    longint dx;
    longint dy;
    longint d;
    longint best_d;
    bit     have;
    int     best_i;
    int     i;
    r = '0;
    case (it.command)
      CMD_CLEAR: begin
        n_pts        = 0;
        dropped_flag = 1'b0;
        return 1'b0;
      end
      CMD_APPEND: begin
        if (n_pts < MAX_POINTS) begin
          pts_x[n_pts] = it.coord_x;
          pts_y[n_pts] = it.coord_y;
          n_pts++;
        end else begin
          dropped_flag = 1'b1;
          drop_cnt++;
        end
        return 1'b0;
      end
      CMD_QUERY: begin
        have   = 1'b0;
        best_d = 0;
        best_i = 0;
        for (i = 0; i < n_pts; i++) begin
          dx = longint'(it.coord_x) - longint'(pts_x[i]);
          dy = longint'(it.coord_y) - longint'(pts_y[i]);
          d  = dx * dx + dy * dy;
          // ties keep the earlier point
          if (!have || d < best_d) begin
            have   = 1'b1;
            best_d = d;
            best_i = i;
          end
        end
        r.found = have;
        if (have) begin
          r.nearest_x        = pts_x[best_i];
          r.nearest_y        = pts_y[best_i];
          r.nearest_index    = best_i[IDX_W-1:0];
          r.distance_squared = best_d[DIST_W-1:0];
        end
        r.store_full = dropped_flag;
        if (n_pts > max_search) max_search = n_pts;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_error(string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_result(out_t got, out_t want);
    if (got.found !== want.found)
      report_error($sformatf("result %0d: found %0b, expected %0b",
                             res_cnt, got.found, want.found));
    if (got.nearest_x !== want.nearest_x)
      report_error($sformatf("result %0d: nearest_x %0d, expected %0d",
                             res_cnt, got.nearest_x, want.nearest_x));
    if (got.nearest_y !== want.nearest_y)
      report_error($sformatf("result %0d: nearest_y %0d, expected %0d",
                             res_cnt, got.nearest_y, want.nearest_y));
    if (got.nearest_index !== want.nearest_index)
      report_error($sformatf("result %0d: nearest_index %0d, expected %0d",
                             res_cnt, got.nearest_index, want.nearest_index));
    if (got.distance_squared !== want.distance_squared)
      report_error($sformatf("result %0d: distance_squared %0d, expected %0d",
                             res_cnt, got.distance_squared, want.distance_squared));
    if (got.store_full !== want.store_full)
      report_error($sformatf("result %0d: store_full %0b, expected %0b",
                             res_cnt, got.store_full, want.store_full));
  endtask

  // offers one transaction and updates the prediction once it is taken
  task automatic send(in_t it, logic typed, out_t want);
    out_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (it.command != CMD_UNUSED) item_cnt++;
    if (search_step(it, r)) nearest_q.push_back(typed ? want : r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (nearest_q.size() != 0);
  endtask

  task automatic random_burst(inout int sent);
    int   n_app;
    int   n_qry;
    int   j;
    int   k;
    int   x;
    int   y;
    in_t  it;
    if ($urandom_range(99) < 15) begin
      // noise: any command, unused one included
      k  = $urandom_range(3);
      it = mk_in(k[1:0], rand_coord(), rand_coord());
      send(it, 1'b0, '0);
      if (it.command != CMD_UNUSED) sent++;
    end else begin
      if ($urandom_range(99) < 80) begin
        send(mk_in(CMD_CLEAR, rand_coord(), rand_coord()), 1'b0, '0);
        sent++;
      end
      n_app = ($urandom_range(99) < 90) ? $urandom_range(12) : $urandom_range(160);
      for (j = 0; j < n_app; j++) begin
        if (n_pts != 0 && $urandom_range(99) < 10) begin
          // repeat the last point to provoke ties
          x = pts_x[n_pts-1];
          y = pts_y[n_pts-1];
        end else begin
          x = rand_coord();
          y = rand_coord();
        end
        send(mk_in(CMD_APPEND, x, y), 1'b0, '0);
        sent++;
      end
      n_qry = $urandom_range(4, 1);
      for (j = 0; j < n_qry; j++) begin
        if (n_pts != 0 && $urandom_range(99) < 40) begin
          k = $urandom_range(n_pts - 1);
          x = int'(pts_x[k]) + int'($urandom_range(64)) - 32;
          y = int'(pts_y[k]) + int'($urandom_range(64)) - 32;
        end else begin
          x = rand_coord();
          y = rand_coord();
        end
        send(mk_in(CMD_QUERY, x, y), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // receiver side, with an occasional long hold counted here
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      res_cnt++;
      if (nearest_q.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing expected", res_cnt));
      end else begin
        head_res = nearest_q.pop_front();
        check_result(out_data_o, head_res);
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cyc_cnt, nearest_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int j;
    int k;

    dir_tab.push_back(mk_row(mk_in(CMD_QUERY, 0, 0), 1'b1, res_of(0, 0, 0, 0, '0, 0)));
    dir_tab.push_back(mk_row(mk_in(CMD_UNUSED, -1, -1), 1'b0, '0));
    dir_tab.push_back(mk_row(mk_in(CMD_APPEND, -32768, -32768), 1'b0, '0));
    dir_tab.push_back(mk_row(mk_in(CMD_QUERY, 32767, 32767), 1'b1,
                             res_of(1, -32768, -32768, 0, 34'd8589672450, 0)));
    dir_tab.push_back(mk_row(mk_in(CMD_APPEND, 32767, 32767), 1'b0, '0));
    dir_tab.push_back(mk_row(mk_in(CMD_QUERY, 0, 0), 1'b0, '0));
    dir_tab.push_back(mk_row(mk_in(CMD_APPEND, 32767, 32767), 1'b0, '0));
    dir_tab.push_back(mk_row(mk_in(CMD_QUERY, 32767, 32767), 1'b1,
                             res_of(1, 32767, 32767, 1, '0, 0)));
    dir_tab.push_back(mk_row(mk_in(CMD_CLEAR, 32767, -32768), 1'b0, '0));
    dir_tab.push_back(mk_row(mk_in(CMD_QUERY, 0, 0), 1'b1, res_of(0, 0, 0, 0, '0, 0)));
    dir_tab.push_back(mk_row(mk_in(CMD_APPEND, 256, 0), 1'b0, '0));
    dir_tab.push_back(mk_row(mk_in(CMD_APPEND, -256, 0), 1'b0, '0));
    dir_tab.push_back(mk_row(mk_in(CMD_QUERY, 0, 0), 1'b1,
                             res_of(1, 256, 0, 0, 34'd65536, 0)));
    dir_tab.push_back(mk_row(mk_in(CMD_APPEND, 0, -1), 1'b0, '0));
    dir_tab.push_back(mk_row(mk_in(CMD_QUERY, 0, 0), 1'b0, '0));
    dir_tab.push_back(mk_row(mk_in(CMD_APPEND, -32768, 32767), 1'b0, '0));
    dir_tab.push_back(mk_row(mk_in(CMD_QUERY, -32768, -32768), 1'b0, '0));
    dir_tab.push_back(mk_row(mk_in(CMD_UNUSED, 21845, -21846), 1'b0, '0));
    dir_tab.push_back(mk_row(mk_in(CMD_QUERY, -21846, 21845), 1'b0, '0));
    dir_tab.push_back(mk_row(mk_in(CMD_CLEAR, 0, 0), 1'b0, '0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_tab[i]) send(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);
    drain();

    for (k = 0; k < 4; k++) begin
      case (k)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 66; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 66; end
        default: begin idle_pct = 28; stall_pct <= 28; end
      endcase
      j = 0;
      while (j < PHASE_ITEMS) random_burst(j);
      drain();
    end

    // long output hold while queries keep coming, so the input backs up
    idle_pct = 0;
    stall_pct <= 0;
    hold_req  <= ~hold_req;
    send(mk_in(CMD_CLEAR, 0, 0), 1'b0, '0);
    for (j = 0; j < 6; j++)
      send(mk_in(CMD_APPEND, rand_coord(), rand_coord()), 1'b0, '0);
    for (j = 0; j < 10; j++)
      send(mk_in(CMD_QUERY, rand_coord(), rand_coord()), 1'b0, '0);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d transactions, %0d results checked, searches over up to %0d points,",
             item_cnt, res_cnt, max_search);
    $display("%0d dropped appends; flow modes: free running, sender gaps, output stalls,",
             drop_cnt);
    $display("both, one %0d-cycle hold", HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
